FILE: hw/rtl/esdt_pkg.sv
package esdt_pkg;

    // Default geometry of the ladder ADC and the free-running timer
    localparam int LADDER_BITS_DEF = 10;
    localparam int TIMER_BITS_DEF  = 32;

    // Fixed register and field widths
    localparam int THR_BITS      = 10;
    localparam int TICKS_BITS    = 32;
    localparam int CODE_BITS     = 16;
    localparam int DIR_BITS      = 2;
    localparam int ACT_BITS      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Register reset values
    localparam logic [THR_BITS-1:0]   NORMAL_THR_RST   = 10'd420;
    localparam logic [THR_BITS-1:0]   ONE_THR_RST      = 10'd150;
    localparam logic [THR_BITS-1:0]   BOTH_THR_RST     = 10'd25;
    localparam logic [TICKS_BITS-1:0] DEBOUNCE_RST     = 32'd960000;
    localparam logic [CODE_BITS-1:0]  MIN_SPAN_RST     = 16'd16;
    localparam logic [CODE_BITS-1:0]  CLOSED_CAL_RST   = 16'd0;
    localparam logic [CODE_BITS-1:0]  OPEN_CAL_RST     = 16'd1023;

    // Switch classes
    typedef enum logic [1:0] {
        CLS_FAULT  = 2'd0,
        CLS_BOTH   = 2'd1,
        CLS_ONE    = 2'd2,
        CLS_NORMAL = 2'd3
    } cls_t;

    // Item actions
    typedef enum logic [ACT_BITS-1:0] {
        ACT_SAMPLE      = 3'd0,
        ACT_TEACH_WRITE = 3'd1,
        ACT_SERVICE     = 3'd2,
        ACT_READ_CLOSED = 3'd3,
        ACT_READ_OPEN   = 3'd4
    } act_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NORMAL_THR = 3'd0,
        REG_ONE_THR    = 3'd1,
        REG_BOTH_THR   = 3'd2,
        REG_DEBOUNCE   = 3'd3,
        REG_MIN_SPAN   = 3'd4,
        REG_CLOSED_CAL = 3'd5,
        REG_OPEN_CAL   = 3'd6
    } cfg_idx_t;

    // Debounce status towards the teach logic: state after the current item
    typedef struct packed {
        cls_t class_next;
        logic end_next;
        logic fault_next;
        logic capture;
    } deb_status_t;

endpackage

FILE: hw/rtl/end_switch_debounce_teach.sv
// End-switch ladder debounce with endpoint capture and teach handshake.
// Each transaction passes the input register, then the result register; the input
// register moves on only when the result slot is free or being read.
// Throughput: one transaction per cycle while m_axis_tready holds.
// Reset: asynchronous, active low; registers take their defaults, the loop
// reads as unverified (fault) and no teach session is armed.
module end_switch_debounce_teach #(
    parameter int LADDER_BITS = esdt_pkg::LADDER_BITS_DEF,
    parameter int TIMER_BITS  = esdt_pkg::TIMER_BITS_DEF,
    localparam int IN_BITS    = LADDER_BITS + esdt_pkg::CODE_BITS + TIMER_BITS
                              + esdt_pkg::DIR_BITS + 1,
    localparam int IN_DATA_BITS = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [esdt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [esdt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ladder_code, wiper_code, timestamp, direction, teach_value, zero pad
    input  logic [IN_DATA_BITS-1:0]             s_axis_tdata,
    // action
    input  logic [esdt_pkg::ACT_BITS-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // end_reached, switch_fault, teach_active, switch_class, read_data,
    // commit, closed_cal, open_cal, zero pad
    output logic [55:0]                         m_axis_tdata
);

    localparam int CW = esdt_pkg::CODE_BITS;

    // Result layout, first field in the highest bits
    typedef struct packed {
        logic [CW-1:0]  open_cal;
        logic [CW-1:0]  closed_cal;
        logic           commit;
        logic [CW-1:0]  read_data;
        esdt_pkg::cls_t switch_class;
        logic           teach_active;
        logic           switch_fault;
        logic           end_reached;
    } result_t;

    localparam int RES_BITS = $bits(result_t);

    typedef struct packed {
        logic read_open;
        logic read_closed;
        logic got_open;
        logic got_closed;
    } cap_flags_t;

    function automatic logic [CW-1:0] span16(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
        span16 = (a > b) ? (a - b) : (b - a);
    endfunction

    // Configuration registers
    logic [esdt_pkg::THR_BITS-1:0]   normal_thr_reg, one_thr_reg, both_thr_reg;
    logic [esdt_pkg::TICKS_BITS-1:0] debounce_reg;
    logic [CW-1:0]                   min_span_reg;

    // Input stage
    logic                  in_valid_reg, in_valid_next;
    logic [IN_BITS-1:0]    in_data_reg;
    esdt_pkg::act_t        in_act_reg;

    // Teach state
    logic                  teach_cmd_reg, teach_cmd_next;
    logic                  armed_reg, armed_next;
    cap_flags_t            flags_reg, flags_next;
    logic [CW-1:0]         closed_cap_reg, closed_cap_next;
    logic [CW-1:0]         open_cap_reg, open_cap_next;
    logic [CW-1:0]         closed_cal_reg, closed_cal_next;
    logic [CW-1:0]         open_cal_reg, open_cal_next;

    // Result stage
    logic                  out_valid_reg, out_valid_next;
    result_t               out_data_reg, out_data_next;

    logic                  s_accept;
    logic                  advance;
    logic                  sample_en;
    logic                  at_open;
    logic [CW-1:0]         read_data;
    logic                  commit;
    esdt_pkg::deb_status_t deb;

    logic [LADDER_BITS-1:0]         f_ladder;
    logic [CW-1:0]                  f_wiper;
    logic [TIMER_BITS-1:0]          f_time;
    logic [esdt_pkg::DIR_BITS-1:0]  f_dir;
    logic                           f_teach;

    // Handshake: the input stage moves on whenever the result slot frees
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign sample_en     = advance && (in_act_reg == esdt_pkg::ACT_SAMPLE);

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Unpack the registered input transaction
    assign f_ladder = in_data_reg[LADDER_BITS-1:0];
    assign f_wiper  = in_data_reg[LADDER_BITS +: CW];
    assign f_time   = in_data_reg[LADDER_BITS + CW +: TIMER_BITS];
    assign f_dir    = in_data_reg[LADDER_BITS + CW + TIMER_BITS +: esdt_pkg::DIR_BITS];
    assign f_teach  = in_data_reg[IN_BITS-1];

    esdt_debounce #(
        .LADDER_BITS (LADDER_BITS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_en      (sample_en),
        .ladder_code    (f_ladder),
        .timestamp      (f_time),
        .normal_thr     (normal_thr_reg),
        .one_thr        (one_thr_reg),
        .both_thr       (both_thr_reg),
        .debounce_ticks (debounce_reg),
        .status         (deb)
    );

    // Stop selection: direction first, nearness to calibration when unknown
    always_comb
    begin
        if (f_dir == 2'b01)
            at_open = 1'b1;
        else if (f_dir[1])
            at_open = 1'b0;
        else
            at_open = span16(f_wiper, open_cal_reg) < span16(f_wiper, closed_cal_reg);
    end

    // Per-item action on teach state
    always_comb
    begin
        teach_cmd_next  = teach_cmd_reg;
        armed_next      = armed_reg;
        flags_next      = flags_reg;
        closed_cap_next = closed_cap_reg;
        open_cap_next   = open_cap_reg;
        closed_cal_next = closed_cal_reg;
        open_cal_next   = open_cal_reg;
        read_data       = '0;
        commit          = 1'b0;

        if (advance)
        begin
            case (in_act_reg)
                esdt_pkg::ACT_SAMPLE:
                begin
                    if (deb.capture)
                    begin
                        if (at_open)
                        begin
                            open_cap_next        = f_wiper;
                            flags_next.got_open  = 1'b1;
                            flags_next.read_open = 1'b0;
                        end
                        else
                        begin
                            closed_cap_next        = f_wiper;
                            flags_next.got_closed  = 1'b1;
                            flags_next.read_closed = 1'b0;
                        end
                    end
                end
                esdt_pkg::ACT_TEACH_WRITE:
                begin
                    teach_cmd_next = f_teach;
                end
                esdt_pkg::ACT_SERVICE:
                begin
                    if (!teach_cmd_reg)
                    begin
                        if (armed_reg)
                        begin
                            armed_next = 1'b0;
                            flags_next = '0;
                        end
                    end
                    else if (!armed_reg)
                    begin
                        armed_next = 1'b1;
                        flags_next = '0;
                    end
                    else if ((flags_reg == '1) &&
                             (span16(closed_cap_reg, open_cap_reg) >= min_span_reg))
                    begin
                        closed_cal_next = closed_cap_reg;
                        open_cal_next   = open_cap_reg;
                        teach_cmd_next  = 1'b0;
                        armed_next      = 1'b0;
                        commit          = 1'b1;
                    end
                end
                esdt_pkg::ACT_READ_CLOSED:
                begin
                    read_data              = closed_cap_reg;
                    flags_next.read_closed = 1'b1;
                end
                esdt_pkg::ACT_READ_OPEN:
                begin
                    read_data            = open_cap_reg;
                    flags_next.read_open = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // Calibration reset writes load the point straight away
        if (cfg_we)
        begin
            case (cfg_index)
                esdt_pkg::REG_CLOSED_CAL: closed_cal_next = cfg_data[CW-1:0];
                esdt_pkg::REG_OPEN_CAL:   open_cal_next   = cfg_data[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Result assembly: state after this item
    always_comb
    begin
        out_data_next.open_cal     = open_cal_next;
        out_data_next.closed_cal   = closed_cal_next;
        out_data_next.commit       = commit;
        out_data_next.read_data    = read_data;
        out_data_next.switch_class = deb.class_next;
        out_data_next.teach_active = armed_next;
        out_data_next.switch_fault = deb.fault_next;
        out_data_next.end_reached  = deb.end_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_thr_reg <= esdt_pkg::NORMAL_THR_RST;
            one_thr_reg    <= esdt_pkg::ONE_THR_RST;
            both_thr_reg   <= esdt_pkg::BOTH_THR_RST;
            debounce_reg   <= esdt_pkg::DEBOUNCE_RST;
            min_span_reg   <= esdt_pkg::MIN_SPAN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esdt_pkg::REG_NORMAL_THR: normal_thr_reg <= cfg_data[esdt_pkg::THR_BITS-1:0];
                esdt_pkg::REG_ONE_THR:    one_thr_reg    <= cfg_data[esdt_pkg::THR_BITS-1:0];
                esdt_pkg::REG_BOTH_THR:   both_thr_reg   <= cfg_data[esdt_pkg::THR_BITS-1:0];
                esdt_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                esdt_pkg::REG_MIN_SPAN:   min_span_reg   <= cfg_data[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control and teach state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            teach_cmd_reg  <= 1'b0;
            armed_reg      <= 1'b0;
            flags_reg      <= '0;
            closed_cap_reg <= '0;
            open_cap_reg   <= '0;
            closed_cal_reg <= esdt_pkg::CLOSED_CAL_RST;
            open_cal_reg   <= esdt_pkg::OPEN_CAL_RST;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            teach_cmd_reg  <= teach_cmd_next;
            armed_reg      <= armed_next;
            flags_reg      <= flags_next;
            closed_cap_reg <= closed_cap_next;
            open_cap_reg   <= open_cap_next;
            closed_cal_reg <= closed_cal_next;
            open_cal_reg   <= open_cal_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
            in_act_reg  <= esdt_pkg::act_t'(s_axis_tuser);
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(56 - RES_BITS){1'b0}}, out_data_reg};

    // Assertions
    a_commit_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.commit |-> !out_data_reg.teach_active)
        else $error("commit reported with teach still armed");

    a_end_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.end_reached ==
                           (out_data_reg.switch_class == esdt_pkg::CLS_ONE)))
        else $error("end flag disagrees with published class");

    a_fault_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.switch_fault ==
                           ((out_data_reg.switch_class == esdt_pkg::CLS_FAULT) ||
                            (out_data_reg.switch_class == esdt_pkg::CLS_BOTH))))
        else $error("fault flag disagrees with published class");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pending item did not reach the result register");

endmodule

FILE: hw/rtl/esdt_debounce.sv
module esdt_debounce #(
    parameter int LADDER_BITS = esdt_pkg::LADDER_BITS_DEF,
    parameter int TIMER_BITS  = esdt_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_en,
    input  logic [LADDER_BITS-1:0]            ladder_code,
    input  logic [TIMER_BITS-1:0]             timestamp,
    input  logic [esdt_pkg::THR_BITS-1:0]     normal_thr,
    input  logic [esdt_pkg::THR_BITS-1:0]     one_thr,
    input  logic [esdt_pkg::THR_BITS-1:0]     both_thr,
    input  logic [esdt_pkg::TICKS_BITS-1:0]   debounce_ticks,
    output esdt_pkg::deb_status_t             status
);

    localparam int CMP_W = (LADDER_BITS > esdt_pkg::THR_BITS) ? LADDER_BITS
                                                               : esdt_pkg::THR_BITS;
    localparam int DEB_W = (TIMER_BITS > esdt_pkg::TICKS_BITS) ? TIMER_BITS
                                                               : esdt_pkg::TICKS_BITS;

    esdt_pkg::cls_t          pub_reg, pub_next;
    esdt_pkg::cls_t          cand_reg, cand_next;
    logic [TIMER_BITS-1:0]   since_reg, since_next;
    logic                    seen_reg, seen_next;
    logic                    end_reg, end_next;
    logic                    fault_reg, fault_next;

    esdt_pkg::cls_t          now_cls;
    logic [CMP_W-1:0]        code_ext;
    logic [TIMER_BITS-1:0]   elapsed;
    logic                    changed;
    logic                    hold_short;
    logic                    publish;

    // Classify against the thresholds, from normal downwards
    always_comb
    begin
        code_ext = CMP_W'(ladder_code);
        if (code_ext >= CMP_W'(normal_thr))
            now_cls = esdt_pkg::CLS_NORMAL;
        else if (code_ext >= CMP_W'(one_thr))
            now_cls = esdt_pkg::CLS_ONE;
        else if (code_ext >= CMP_W'(both_thr))
            now_cls = esdt_pkg::CLS_BOTH;
        else
            now_cls = esdt_pkg::CLS_FAULT;
    end

    // Candidate tracking and hold-time check (wrapping elapsed time)
    always_comb
    begin
        changed    = (now_cls != cand_reg);
        since_next = changed ? timestamp : since_reg;
        elapsed    = timestamp - since_next;
        hold_short = (DEB_W'(elapsed) < DEB_W'(debounce_ticks));
        publish    = sample_en
                   && !(changed && seen_reg)
                   && !(seen_reg && (now_cls == pub_reg))
                   && !(seen_reg && hold_short);
    end

    // Next state
    always_comb
    begin
        cand_next  = cand_reg;
        seen_next  = seen_reg;
        pub_next   = pub_reg;
        end_next   = end_reg;
        fault_next = fault_reg;
        if (sample_en)
        begin
            cand_next = now_cls;
        end
        if (publish)
        begin
            seen_next  = 1'b1;
            pub_next   = now_cls;
            end_next   = (now_cls == esdt_pkg::CLS_ONE);
            fault_next = !((now_cls == esdt_pkg::CLS_NORMAL) ||
                           (now_cls == esdt_pkg::CLS_ONE));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pub_reg   <= esdt_pkg::CLS_FAULT;
            cand_reg  <= esdt_pkg::CLS_FAULT;
            since_reg <= '0;
            seen_reg  <= 1'b0;
            end_reg   <= 1'b0;
            fault_reg <= 1'b1;
        end
        else
        begin
            pub_reg   <= pub_next;
            cand_reg  <= cand_next;
            if (sample_en)
                since_reg <= since_next;
            seen_reg  <= seen_next;
            end_reg   <= end_next;
            fault_reg <= fault_next;
        end
    end

    // Capture on each entry into the one-active class
    always_comb
    begin
        status.class_next = pub_next;
        status.end_next   = end_next;
        status.fault_next = fault_next;
        status.capture    = publish && (now_cls == esdt_pkg::CLS_ONE)
                          && !(seen_reg && (pub_reg == esdt_pkg::CLS_ONE));
    end

endmodule
